// File: rtl/core/sia_pkg.sv
// ============================================================================
// sia_pkg: shared types, codes and helpers for the saturating interval ALU
// Bound limits, operation/condition/type codes, clamp and type-fit functions.
// ============================================================================
package sia_pkg;

  localparam int unsigned BOUND_WIDTH = 64;

  // Signed limits of BOUND_WIDTH bits, held in 64-bit words
  localparam logic signed [63:0] BMAX = $signed((64'd1 << (BOUND_WIDTH - 1)) - 64'd1);
  localparam logic signed [63:0] BMIN = ~BMAX;

  localparam logic signed [63:0] I64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;

  // Divider: quotient bits per stage and stage count
  localparam int unsigned DIV_BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES = 64 / DIV_BITS_PER_STAGE;
  // Cycles from the operand register to the aligned result
  localparam int unsigned DIV_LAT = DIV_STAGES + 3;
  localparam int unsigned MUL_LAT = 6;

  typedef enum logic [3:0] {
    ACT_NEG    = 4'd0,
    ACT_ABS    = 4'd1,
    ACT_ADD    = 4'd2,
    ACT_SUB    = 4'd3,
    ACT_MUL    = 4'd4,
    ACT_DIV    = 4'd5,
    ACT_MOD    = 4'd6,
    ACT_JOIN   = 4'd7,
    ACT_NARROW = 4'd8
  } action_e;

  typedef enum logic [3:0] {
    CC_EQ = 4'd0,
    CC_NE = 4'd1,
    CC_LT = 4'd2,
    CC_LE = 4'd3,
    CC_GT = 4'd4,
    CC_GE = 4'd5,
    CC_B  = 4'd6,
    CC_BE = 4'd7,
    CC_A  = 4'd8,
    CC_AE = 4'd9
  } cond_e;

  typedef enum logic [3:0] {
    TY_BOOL = 4'd0,
    TY_U8   = 4'd1,
    TY_U16  = 4'd2,
    TY_U32  = 4'd3,
    TY_I8   = 4'd4,
    TY_I16  = 4'd5,
    TY_I32  = 4'd6,
    TY_I64  = 4'd7,
    TY_REF  = 4'd8
  } type_e;

  typedef struct packed {
    logic signed [63:0] lo;
    logic signed [63:0] hi;
  } bnd_t;

  typedef struct packed {
    bnd_t r;
    bnd_t s;
  } res_t;

  typedef struct packed {
    action_e            action;
    logic signed [63:0] a_low;
    logic signed [63:0] a_high;
    logic signed [63:0] b_low;
    logic signed [63:0] b_high;
    cond_e              cond;
    type_e              a_type;
    type_e              b_type;
  } op_t;

  typedef struct packed {
    action_e action;
    type_e   a_type;
    type_e   b_type;
  } tag_t;

  function automatic logic signed [63:0] smin(logic signed [63:0] a, logic signed [63:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [63:0] smax(logic signed [63:0] a, logic signed [63:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [63:0] clampb(logic signed [63:0] v);
    if (v > BMAX) return BMAX;
    if (v < BMIN) return BMIN;
    return v;
  endfunction

  // Saturate a 65-bit exact sum to the bound limits
  function automatic logic signed [63:0] sat65(logic signed [64:0] v);
    logic signed [64:0] hi_lim;
    logic signed [64:0] lo_lim;
    hi_lim = {BMAX[63], BMAX};
    lo_lim = {BMIN[63], BMIN};
    if (v > hi_lim) return BMAX;
    if (v < lo_lim) return BMIN;
    return v[63:0];
  endfunction

  function automatic logic signed [63:0] neg_sat(logic signed [63:0] x);
    logic signed [64:0] e;
    e = {x[63], x};
    return sat65(-e);
  endfunction

  function automatic logic signed [63:0] type_lo(type_e t);
    case (t)
      TY_I8:   return -64'sd128;
      TY_I16:  return -64'sd32768;
      TY_I32:  return -64'sd2147483648;
      TY_BOOL, TY_U8, TY_U16, TY_U32, TY_REF: return 64'sd0;
      default: return I64_MIN;
    endcase
  endfunction

  function automatic logic signed [63:0] type_hi(type_e t);
    case (t)
      TY_BOOL: return 64'sd1;
      TY_U8:   return 64'sd255;
      TY_U16:  return 64'sd65535;
      TY_U32:  return 64'sd4294967295;
      TY_I8:   return 64'sd127;
      TY_I16:  return 64'sd32767;
      TY_I32:  return 64'sd2147483647;
      default: return I64_MAX;
    endcase
  endfunction

  // Whole type range if either bound falls outside it
  function automatic bnd_t fit(type_e t, bnd_t b);
    logic signed [63:0] tl;
    logic signed [63:0] th;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    bnd_t o;
    tl = smax(type_lo(t), BMIN);
    th = smin(type_hi(t), BMAX);
    lo = b.lo;
    hi = b.hi;
    if (lo < tl || lo > th || hi < tl || hi > th) begin
      o.lo = tl;
      o.hi = th;
    end else begin
      o.lo = lo;
      o.hi = hi;
    end
    return o;
  endfunction

endpackage

// File: rtl/core/sia_if.sv
// ============================================================================
// sia_if: request and result channels of the saturating interval ALU
// Valid/ready handshake; a request moves when valid and ready are both high.
// ============================================================================
interface sia_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         action;
  logic signed [63:0] a_low;
  logic signed [63:0] a_high;
  logic signed [63:0] b_low;
  logic signed [63:0] b_high;
  logic [3:0]         cond;
  logic [3:0]         a_type;
  logic [3:0]         b_type;

  modport source (
    output valid, action, a_low, a_high, b_low, b_high, cond, a_type, b_type,
    input  ready
  );
  modport sink (
    input  valid, action, a_low, a_high, b_low, b_high, cond, a_type, b_type,
    output ready
  );
endinterface

interface sia_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] r_low;
  logic signed [63:0] r_high;
  logic signed [63:0] s_low;
  logic signed [63:0] s_high;

  modport source (
    output valid, r_low, r_high, s_low, s_high,
    input  ready
  );
  modport sink (
    input  valid, r_low, r_high, s_low, s_high,
    output ready
  );
endinterface

// File: rtl/core/sia_basic.sv
// ============================================================================
// sia_basic: single-stage interval operations
// Neg, abs, add, sub, mod, join and narrow, before the type fit.
// ============================================================================
module sia_basic import sia_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  op_t  op_i,
  output res_t res_o
);

  res_t res_d, res_q;

  always_comb begin
    logic signed [63:0] al, ah, bl, bh;
    logic signed [63:0] m1, m2;
    logic signed [63:0] n0, n1, n2, n3;
    logic [63:0]        mg;
    logic               gt, ge, lt, le, eq, full, lc, rc;
    al = op_i.a_low;
    ah = op_i.a_high;
    bl = op_i.b_low;
    bh = op_i.b_high;
    res_d = '0;
    m1 = '0;
    m2 = '0;
    mg = '0;
    gt = (op_i.cond == CC_GT) || (op_i.cond == CC_A);
    ge = (op_i.cond == CC_GE) || (op_i.cond == CC_AE);
    lt = (op_i.cond == CC_LT) || (op_i.cond == CC_B);
    le = (op_i.cond == CC_LE) || (op_i.cond == CC_BE);
    eq = (op_i.cond == CC_EQ);
    full = 1'b0;
    lc = (al == ah);
    rc = (bl == bh);
    n0 = al;
    n1 = ah;
    n2 = bl;
    n3 = bh;
    case (op_i.action)
      ACT_NEG: begin
        res_d.r.lo = neg_sat(ah);
        res_d.r.hi = neg_sat(al);
      end
      ACT_ABS: begin
        m1 = (al < 0) ? neg_sat(al) : clampb(al);
        m2 = (ah < 0) ? neg_sat(ah) : clampb(ah);
        res_d.r.hi = smax(m1, m2);
        res_d.r.lo = (al[63] == ah[63]) ? smin(m1, m2) : 64'sd0;
      end
      ACT_ADD: begin
        res_d.r.lo = sat65({al[63], al} + {bl[63], bl});
        res_d.r.hi = sat65({ah[63], ah} + {bh[63], bh});
      end
      ACT_SUB: begin
        res_d.r.lo = sat65({al[63], al} - {bh[63], bh});
        res_d.r.hi = sat65({ah[63], ah} - {bl[63], bl});
      end
      ACT_MOD: begin
        if (bh == 0) begin
          res_d.r.lo = BMIN;
          res_d.r.hi = BMAX;
        end else begin
          mg = (bh[63] ? (64'd0 - bh) : bh) - 64'd1;
          res_d.r.lo = 64'sd0;
          res_d.r.hi = (mg > BMAX) ? BMAX : $signed(mg);
        end
      end
      ACT_JOIN: begin
        res_d.r.lo = clampb(smin(al, bl));
        res_d.r.hi = clampb(smax(ah, bh));
      end
      ACT_NARROW: begin
        if (op_i.cond == CC_NE) begin
          // single value at an end of the other interval: pull that end in
          if (lc && !rc) begin
            if (al == bl) n2 = (bl == I64_MAX) ? bl : bl + 64'sd1;
            else if (al == bh) n3 = (bh == I64_MIN) ? bh : bh - 64'sd1;
          end else if (!lc && rc) begin
            if (bl == al) n0 = (al == I64_MAX) ? al : al + 64'sd1;
            else if (bl == ah) n1 = (ah == I64_MIN) ? ah : ah - 64'sd1;
          end
        end else if (al <= bl && bl <= ah && ah <= bh) begin
          if (gt) begin
            if (bl == ah) full = 1'b1;
            else begin
              n0 = bl + 64'sd1; n1 = ah; n2 = bl; n3 = ah - 64'sd1;
            end
          end else if (ge || eq) begin
            n0 = bl; n1 = ah; n2 = bl; n3 = ah;
          end
        end else if (al <= ah && ah < bl && bl <= bh) begin
          if (gt || ge || eq) full = 1'b1;
        end else if (al <= bl && bl <= bh && bh <= ah) begin
          if (gt) n0 = bl + 64'sd1;
          else if (ge) n0 = bl;
          else if (lt) begin
            if (al == bh) full = 1'b1;
            else n1 = bh - 64'sd1;
          end else if (le) n1 = bh;
          else if (eq) begin
            n0 = bl; n1 = bh;
          end
        end else if (bl <= al && al <= bh && bh <= ah) begin
          if (lt) begin
            if (al == bh) full = 1'b1;
            else begin
              n0 = al; n1 = bh - 64'sd1; n2 = al + 64'sd1; n3 = bh;
            end
          end else if (le || eq) begin
            n0 = al; n1 = bh; n2 = al; n3 = bh;
          end
        end else if (bl <= bh && bh < al && al <= ah) begin
          if (lt || le || eq) full = 1'b1;
        end else if (bl <= al && al <= ah && ah <= bh) begin
          if (gt) n3 = ah - 64'sd1;
          else if (ge) n3 = ah;
          else if (lt) n2 = al + 64'sd1;
          else if (le) n2 = al;
          else if (eq) begin
            n2 = al; n3 = ah;
          end
        end
        if (full) begin
          n0 = BMIN; n1 = BMAX; n2 = BMIN; n3 = BMAX;
        end
        res_d.r.lo = n0;
        res_d.r.hi = n1;
        res_d.s.lo = n2;
        res_d.s.hi = n3;
      end
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// File: rtl/core/sia_mul.sv
// ============================================================================
// sia_mul: pipelined saturating interval multiply
// Four 64x64 products from 32x32 partials, saturated, then min and max.
// ============================================================================
module sia_mul import sia_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  op_t  op_i,
  output bnd_t res_o
);

  // stage 1: magnitudes and product signs
  logic [63:0]        mag_q [4];
  logic [3:0]         neg_q;
  // stage 2: partial products, ll lh hl hh
  logic [63:0]        pp_q [4][4];
  logic [3:0]         neg2_q;
  // stage 3: folded middle terms
  logic [64:0]        mid_q [4];
  logic [127:0]       hl_q [4];
  logic [3:0]         neg3_q;
  // stage 4: full products
  logic [127:0]       prod_q [4];
  logic [3:0]         neg4_q;
  // stage 5: saturated products
  logic signed [63:0] sat_q [4];
  // stage 6: result
  bnd_t               res_q;

  logic [63:0]        mag_d [4];
  logic [3:0]         neg_d;
  logic signed [63:0] sat_d [4];

  always_comb begin
    logic signed [63:0] v [4];
    v[0] = op_i.a_low;
    v[1] = op_i.a_high;
    v[2] = op_i.b_low;
    v[3] = op_i.b_high;
    for (int i = 0; i < 4; i++) begin
      mag_d[i] = v[i][63] ? (64'd0 - v[i]) : v[i];
    end
    // product order: al*bl, al*bh, ah*bl, ah*bh
    neg_d[0] = v[0][63] ^ v[2][63];
    neg_d[1] = v[0][63] ^ v[3][63];
    neg_d[2] = v[1][63] ^ v[2][63];
    neg_d[3] = v[1][63] ^ v[3][63];
  end

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      if (!neg4_q[p]) begin
        sat_d[p] = (|prod_q[p][127:63]) ? BMAX : clampb($signed(prod_q[p][63:0]));
      end else if (prod_q[p] > {64'd0, 1'b1, 63'd0}) begin
        sat_d[p] = BMIN;
      end else begin
        sat_d[p] = clampb($signed(64'd0 - prod_q[p][63:0]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
      for (int p = 0; p < 4; p++) begin
        pp_q[p][0] <= mag_q[p / 2][31:0]  * mag_q[2 + p % 2][31:0];
        pp_q[p][1] <= mag_q[p / 2][31:0]  * mag_q[2 + p % 2][63:32];
        pp_q[p][2] <= mag_q[p / 2][63:32] * mag_q[2 + p % 2][31:0];
        pp_q[p][3] <= mag_q[p / 2][63:32] * mag_q[2 + p % 2][63:32];
        mid_q[p]   <= {1'b0, pp_q[p][1]} + {1'b0, pp_q[p][2]};
        hl_q[p]    <= {pp_q[p][3], pp_q[p][0]};
        prod_q[p]  <= hl_q[p] + {31'd0, mid_q[p], 32'd0};
      end
      neg2_q <= neg_q;
      neg3_q <= neg2_q;
      neg4_q <= neg3_q;
      sat_q  <= sat_d;
      res_q.lo <= smin(smin(sat_q[0], sat_q[1]), smin(sat_q[2], sat_q[3]));
      res_q.hi <= smax(smax(sat_q[0], sat_q[1]), smax(sat_q[2], sat_q[3]));
    end
  end

  assign res_o = res_q;

endmodule

// File: rtl/core/sia_div.sv
// ============================================================================
// sia_div: pipelined interval divide by a constant divisor
// Two restoring quotients share one divisor, two bits per stage.
// ============================================================================
module sia_div import sia_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  op_t  op_i,
  output bnd_t res_o
);

  function automatic logic [127:0] div_step(logic [63:0] rem, logic [63:0] quo,
                                            logic [63:0] dvs);
    logic [64:0] t;
    logic [63:0] r;
    logic [63:0] q;
    r = rem;
    q = quo;
    for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
      t = {r, q[63]};
      q = {q[62:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        t = t - {1'b0, dvs};
        q[0] = 1'b1;
      end
      r = t[63:0];
    end
    return {r, q};
  endfunction

  // prep stage
  logic [63:0]        na_q, nh_q, dvs_q;
  logic               sa_q, sh_q, full_q;
  // iteration stages
  logic [63:0]        ra_q [DIV_STAGES];
  logic [63:0]        qa_q [DIV_STAGES];
  logic [63:0]        rh_q [DIV_STAGES];
  logic [63:0]        qh_q [DIV_STAGES];
  logic [63:0]        dv_q [DIV_STAGES];
  logic               sga_q [DIV_STAGES];
  logic               sgh_q [DIV_STAGES];
  logic               fl_q [DIV_STAGES];
  logic [127:0]       nxa [DIV_STAGES];
  logic [127:0]       nxh [DIV_STAGES];
  // signed quotients
  logic signed [63:0] m1_q, m2_q;
  logic               full2_q;
  bnd_t               res_q;

  always_comb begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        nxa[s] = div_step(64'd0, na_q, dvs_q);
        nxh[s] = div_step(64'd0, nh_q, dvs_q);
      end else begin
        nxa[s] = div_step(ra_q[s-1], qa_q[s-1], dv_q[s-1]);
        nxh[s] = div_step(rh_q[s-1], qh_q[s-1], dv_q[s-1]);
      end
    end
  end

  function automatic logic signed [63:0] q_sign(logic neg, logic [63:0] q);
    // only most negative over minus one yields 2^63 with a positive sign
    if (!neg) return q[63] ? BMAX : clampb($signed(q));
    return clampb($signed(64'd0 - q));
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      na_q   <= op_i.a_low[63]  ? (64'd0 - op_i.a_low)  : op_i.a_low;
      nh_q   <= op_i.a_high[63] ? (64'd0 - op_i.a_high) : op_i.a_high;
      dvs_q  <= op_i.b_low[63]  ? (64'd0 - op_i.b_low)  : op_i.b_low;
      sa_q   <= op_i.a_low[63]  ^ op_i.b_low[63];
      sh_q   <= op_i.a_high[63] ^ op_i.b_low[63];
      full_q <= (op_i.b_low != op_i.b_high) || (op_i.b_low == 0);
      for (int s = 0; s < DIV_STAGES; s++) begin
        ra_q[s] <= nxa[s][127:64];
        qa_q[s] <= nxa[s][63:0];
        rh_q[s] <= nxh[s][127:64];
        qh_q[s] <= nxh[s][63:0];
        if (s == 0) begin
          dv_q[s]  <= dvs_q;
          sga_q[s] <= sa_q;
          sgh_q[s] <= sh_q;
          fl_q[s]  <= full_q;
        end else begin
          dv_q[s]  <= dv_q[s-1];
          sga_q[s] <= sga_q[s-1];
          sgh_q[s] <= sgh_q[s-1];
          fl_q[s]  <= fl_q[s-1];
        end
      end
      m1_q    <= q_sign(sga_q[DIV_STAGES-1], qa_q[DIV_STAGES-1]);
      m2_q    <= q_sign(sgh_q[DIV_STAGES-1], qh_q[DIV_STAGES-1]);
      full2_q <= fl_q[DIV_STAGES-1];
      if (full2_q) begin
        res_q.lo <= BMIN;
        res_q.hi <= BMAX;
      end else begin
        res_q.lo <= smin(m1_q, m2_q);
        res_q.hi <= smax(m1_q, m2_q);
      end
    end
  end

  assign res_o = res_q;

endmodule

// File: rtl/core/saturating_interval_alu_core.sv
// ============================================================================
// saturating_interval_alu_core: saturating 64-bit interval arithmetic
// Throughput: one request per cycle while the output is not stalled; the depth is
//   set by the restoring divider, 64 quotient steps at two bits per pipeline stage.
// Reset clears only the valid bits; the datapath registers are not reset.
// ============================================================================
module saturating_interval_alu_core import sia_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sia_in_if.sink    in_i,
  sia_out_if.source out_o
);

  // Delays that line every unit up with the divider output
  localparam int unsigned BAS_DLY = DIV_LAT - 1;
  localparam int unsigned MUL_DLY = DIV_LAT - MUL_LAT;

  // Whole pipeline advances together; frozen only when the result
  // register is full and not taken.
  logic en;
  logic out_vld_q;

  assign en = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // Operand register
  op_t  op_q;
  logic vld_a_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q.action <= action_e'(in_i.action);
      op_q.a_low  <= in_i.a_low;
      op_q.a_high <= in_i.a_high;
      op_q.b_low  <= in_i.b_low;
      op_q.b_high <= in_i.b_high;
      op_q.cond   <= cond_e'(in_i.cond);
      op_q.a_type <= type_e'(in_i.a_type);
      op_q.b_type <= type_e'(in_i.b_type);
    end
  end

  // Execution units
  res_t bas_res;
  bnd_t mul_res;
  bnd_t div_res;

  sia_basic u_basic (
    .clk_i (clk_i),
    .en_i  (en),
    .op_i  (op_q),
    .res_o (bas_res)
  );

  sia_mul u_mul (
    .clk_i (clk_i),
    .en_i  (en),
    .op_i  (op_q),
    .res_o (mul_res)
  );

  sia_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .op_i  (op_q),
    .res_o (div_res)
  );

  // Alignment lines: valid bits, codes, short-path results
  logic vld_q [DIV_LAT];
  tag_t tag_q [DIV_LAT];
  res_t bas_q [BAS_DLY];
  bnd_t mul_q [MUL_DLY];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q   <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_a_q   <= in_i.valid;
      vld_q[0]  <= vld_a_q;
      for (int i = 1; i < DIV_LAT; i++) vld_q[i] <= vld_q[i-1];
      out_vld_q <= vld_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag_q[0] <= '{action: op_q.action, a_type: op_q.a_type, b_type: op_q.b_type};
      for (int i = 1; i < DIV_LAT; i++) tag_q[i] <= tag_q[i-1];
      bas_q[0] <= bas_res;
      for (int i = 1; i < BAS_DLY; i++) bas_q[i] <= bas_q[i-1];
      mul_q[0] <= mul_res;
      for (int i = 1; i < MUL_DLY; i++) mul_q[i] <= mul_q[i-1];
    end
  end

  // Unit select and type fit
  res_t fin_d, fin_q;

  always_comb begin
    tag_t t;
    bnd_t pre_r;
    t = tag_q[DIV_LAT-1];
    fin_d = '0;
    case (t.action)
      ACT_MUL: pre_r = mul_q[MUL_DLY-1];
      ACT_DIV: pre_r = div_res;
      default: pre_r = bas_q[BAS_DLY-1].r;
    endcase
    case (t.action)
      ACT_NEG, ACT_ABS, ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD, ACT_JOIN: begin
        fin_d.r = fit(t.a_type, pre_r);
      end
      ACT_NARROW: begin
        fin_d.r = fit(t.a_type, pre_r);
        fin_d.s = fit(t.b_type, bas_q[BAS_DLY-1].s);
      end
      default: fin_d = '0;  // unknown action: all zero
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) fin_q <= fin_d;
  end

  assign out_o.valid  = out_vld_q;
  assign out_o.r_low  = fin_q.r.lo;
  assign out_o.r_high = fin_q.r.hi;
  assign out_o.s_low  = fin_q.s.lo;
  assign out_o.s_high = fin_q.s.hi;

endmodule

// File: verif/tb_top.sv
// ============================================================================
// tb_top: self-checking bench for saturating_interval_alu_core
// Drives interval requests over the valid/ready channel, predicts each result
// bound for bound, and compares results in order under random back-pressure.
// ============================================================================
module tb_top;
  import sia_pkg::*;

  typedef logic signed [63:0]  bound_t;
  typedef logic signed [127:0] wide_t;

  // Raw request; codes stay 4 bits wide so out-of-range codes can be sent
  typedef struct {
    logic [3:0] action;
    bound_t     a_low, a_high, b_low, b_high;
    logic [3:0] cond, a_type, b_type;
  } req_t;

  typedef struct {
    bound_t r_low, r_high, s_low, s_high;
  } rsp_t;

  logic clk_i;
  logic rst_ni;

  sia_in_if  in_if ();
  sia_out_if out_if ();

  saturating_interval_alu_core u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Interval arithmetic predictor
  // --------------------------------------------------------------------------
  function automatic bound_t sat_wide(wide_t v);
    wide_t hi_lim;
    wide_t lo_lim;
    hi_lim = BMAX;
    lo_lim = BMIN;
    if (v > hi_lim) return BMAX;
    if (v < lo_lim) return BMIN;
    return v[63:0];
  endfunction

  function automatic bound_t min_b(bound_t a, bound_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic bound_t max_b(bound_t a, bound_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic bound_t quot_sat(bound_t n, bound_t d);
    if (n == I64_MIN && d == -64'sd1) return BMAX;
    return n / d;
  endfunction

  // Type range of a clamp code; unknown codes behave as i64
  function automatic void type_range(logic [3:0] t, output bound_t lo, output bound_t hi);
    lo = 64'sd0;
    case (t)
      TY_BOOL: hi = 64'sd1;
      TY_U8:   hi = 64'sd255;
      TY_U16:  hi = 64'sd65535;
      TY_U32:  hi = 64'sd4294967295;
      TY_I8:   begin lo = -64'sd128;        hi = 64'sd127;        end
      TY_I16:  begin lo = -64'sd32768;      hi = 64'sd32767;      end
      TY_I32:  begin lo = -64'sd2147483648; hi = 64'sd2147483647; end
      TY_REF:  hi = I64_MAX;
      default: begin lo = I64_MIN;          hi = I64_MAX;         end
    endcase
    lo = max_b(lo, BMIN);
    hi = min_b(hi, BMAX);
  endfunction

  function automatic void fit_type(logic [3:0] t, inout bound_t lo, inout bound_t hi);
    bound_t tl, th;
    type_range(t, tl, th);
    if (lo < tl || lo > th || hi < tl || hi > th) begin
      lo = tl;
      hi = th;
    end
  endfunction

  // Refine a and b under "a cond b"
  function automatic void narrow_pair(logic [3:0] cc, inout bound_t ll, inout bound_t lr,
                                      inout bound_t rl, inout bound_t rr);
    logic   gt, ge, lt, le, eq, full, lc, rc;
    bound_t n0, n1, n2, n3;
    gt = (cc == CC_GT) || (cc == CC_A);
    ge = (cc == CC_GE) || (cc == CC_AE);
    lt = (cc == CC_LT) || (cc == CC_B);
    le = (cc == CC_LE) || (cc == CC_BE);
    eq = (cc == CC_EQ);
    full = 1'b0;
    n0 = ll; n1 = lr; n2 = rl; n3 = rr;
    if (cc == CC_NE) begin
      lc = (ll == lr);
      rc = (rl == rr);
      // single value on one side touching an end of the other: step that end in
      if (lc && !rc) begin
        if (ll == rl) n2 = (rl == I64_MAX) ? rl : rl + 1;
        else if (ll == rr) n3 = (rr == I64_MIN) ? rr : rr - 1;
      end else if (!lc && rc) begin
        if (rl == ll) n0 = (ll == I64_MAX) ? ll : ll + 1;
        else if (rl == lr) n1 = (lr == I64_MIN) ? lr : lr - 1;
      end
    end else if (ll <= rl && rl <= lr && lr <= rr) begin
      if (gt) begin
        if (rl == lr) full = 1'b1;
        else begin n0 = rl + 1; n1 = lr; n2 = rl; n3 = lr - 1; end
      end else if (ge || eq) begin
        n0 = rl; n1 = lr; n2 = rl; n3 = lr;
      end
    end else if (ll <= lr && lr < rl && rl <= rr) begin
      if (gt || ge || eq) full = 1'b1;
    end else if (ll <= rl && rl <= rr && rr <= lr) begin
      if (gt) n0 = rl + 1;
      else if (ge) n0 = rl;
      else if (lt) begin
        if (ll == rr) full = 1'b1;
        else n1 = rr - 1;
      end else if (le) n1 = rr;
      else if (eq) begin n0 = rl; n1 = rr; end
    end else if (rl <= ll && ll <= rr && rr <= lr) begin
      if (lt) begin
        if (ll == rr) full = 1'b1;
        else begin n0 = ll; n1 = rr - 1; n2 = ll + 1; n3 = rr; end
      end else if (le || eq) begin
        n0 = ll; n1 = rr; n2 = ll; n3 = rr;
      end
    end else if (rl <= rr && rr < ll && ll <= lr) begin
      if (lt || le || eq) full = 1'b1;
    end else if (rl <= ll && ll <= lr && lr <= rr) begin
      if (gt) n3 = lr - 1;
      else if (ge) n3 = lr;
      else if (lt) n2 = ll + 1;
      else if (le) n2 = ll;
      else if (eq) begin n2 = ll; n3 = lr; end
    end
    if (full) begin
      n0 = BMIN; n1 = BMAX; n2 = BMIN; n3 = BMAX;
    end
    ll = n0; lr = n1; rl = n2; rr = n3;
  endfunction

  function automatic rsp_t predict_interval(req_t q);
    rsp_t   p;
    wide_t  wal, wah, wbl, wbh;
    bound_t m1, m2, m3, m4;
    bound_t nl, nh, ml, mh;
    wal = q.a_low; wah = q.a_high; wbl = q.b_low; wbh = q.b_high;
    p = '{default: 64'sd0};
    case (q.action)
      ACT_NEG: begin
        p.r_low  = sat_wide(-wah);
        p.r_high = sat_wide(-wal);
      end
      ACT_ABS: begin
        m1 = sat_wide(q.a_low  < 0 ? -wal : wal);
        m2 = sat_wide(q.a_high < 0 ? -wah : wah);
        p.r_high = max_b(m1, m2);
        p.r_low  = ((q.a_low < 0) == (q.a_high < 0)) ? min_b(m1, m2) : 64'sd0;
      end
      ACT_ADD: begin
        p.r_low  = sat_wide(wal + wbl);
        p.r_high = sat_wide(wah + wbh);
      end
      ACT_SUB: begin
        p.r_low  = sat_wide(wal - wbh);
        p.r_high = sat_wide(wah - wbl);
      end
      ACT_MUL: begin
        m1 = sat_wide(wal * wbl); m2 = sat_wide(wal * wbh);
        m3 = sat_wide(wah * wbl); m4 = sat_wide(wah * wbh);
        p.r_low  = min_b(min_b(m1, m2), min_b(m3, m4));
        p.r_high = max_b(max_b(m1, m2), max_b(m3, m4));
      end
      ACT_DIV: begin
        // only a nonzero constant divisor gives a bounded quotient
        if (q.b_low != q.b_high || q.b_low == 0) begin
          p.r_low = BMIN; p.r_high = BMAX;
        end else begin
          m1 = quot_sat(q.a_low, q.b_low);
          m2 = quot_sat(q.a_high, q.b_low);
          p.r_low  = min_b(m1, m2);
          p.r_high = max_b(m1, m2);
        end
      end
      ACT_MOD: begin
        if (q.b_high == 0) begin
          p.r_low = BMIN; p.r_high = BMAX;
        end else begin
          p.r_low  = 64'sd0;
          p.r_high = sat_wide((q.b_high < 0 ? -wbh : wbh) - 1);
        end
      end
      ACT_JOIN: begin
        p.r_low  = min_b(q.a_low, q.b_low);
        p.r_high = max_b(q.a_high, q.b_high);
      end
      ACT_NARROW: begin
        nl = q.a_low; nh = q.a_high; ml = q.b_low; mh = q.b_high;
        narrow_pair(q.cond, nl, nh, ml, mh);
        fit_type(q.b_type, ml, mh);
        p.r_low = nl; p.r_high = nh; p.s_low = ml; p.s_high = mh;
      end
      default: return p;  // unknown action: all zero, no type fit
    endcase
    fit_type(q.a_type, p.r_low, p.r_high);
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: in-order queue of predicted intervals
  // --------------------------------------------------------------------------
  class interval_scoreboard;
    rsp_t expected_q[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    function void note_request(req_t q);
      expected_q.push_back(predict_interval(q));
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: r=[%0d,%0d] s=[%0d,%0d]",
               got.r_low, got.r_high, got.s_low, got.s_high);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.r_low !== e.r_low) begin
        $error("r_low expected %0d actual %0d", e.r_low, got.r_low); errors++;
      end
      if (got.r_high !== e.r_high) begin
        $error("r_high expected %0d actual %0d", e.r_high, got.r_high); errors++;
      end
      if (got.s_low !== e.s_low) begin
        $error("s_low expected %0d actual %0d", e.s_low, got.s_low); errors++;
      end
      if (got.s_high !== e.s_high) begin
        $error("s_high expected %0d actual %0d", e.s_high, got.s_high); errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  interval_scoreboard sb = new();

  // Idle knobs, percent per cycle
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  bit          hold_req;

  // Request monitor
  always @(posedge clk_i) begin
    req_t q;
    if (rst_ni && in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
      q.action = in_if.action;
      q.a_low  = in_if.a_low;  q.a_high = in_if.a_high;
      q.b_low  = in_if.b_low;  q.b_high = in_if.b_high;
      q.cond   = in_if.cond;   q.a_type = in_if.a_type; q.b_type = in_if.b_type;
      sb.note_request(q);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    rsp_t got;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.r_low = out_if.r_low; got.r_high = out_if.r_high;
      got.s_low = out_if.s_low; got.s_high = out_if.s_high;
      sb.check_result(got);
    end
  end

  // Result receiver; a hold request turns into a long stall counted here
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic req_t mk(logic [3:0] act, bound_t al, bound_t ah, bound_t bl, bound_t bh,
                              logic [3:0] cc, logic [3:0] ta, logic [3:0] tb);
    req_t q;
    q.action = act; q.a_low = al; q.a_high = ah; q.b_low = bl; q.b_high = bh;
    q.cond = cc; q.a_type = ta; q.b_type = tb;
    return q;
  endfunction

  // Bound values biased to small numbers and the limits, plus 32-bit and 24-bit spreads
  function automatic bound_t pick_bound();
    case ($urandom_range(6))
      0, 1: return $signed(64'($urandom_range(20))) - 64'sd10;
      2:    return I64_MIN + 64'($urandom_range(3));
      3:    return I64_MAX - 64'($urandom_range(3));
      4:    return {$urandom, $urandom};
      5:    return $signed({{32{1'b0}}, $urandom}) - 64'sd2147483648;
      default: return {{40{1'b0}}, 24'($urandom)};
    endcase
  endfunction

  function automatic req_t random_request();
    req_t   q;
    bound_t t;
    q.action = ($urandom_range(19) == 0) ? 4'($urandom) : 4'($urandom_range(8));
    // narrow gets extra weight: its overlap cases are the deepest logic
    if ($urandom_range(2) == 0) q.action = ACT_NARROW;
    q.a_low = pick_bound(); q.a_high = pick_bound();
    q.b_low = pick_bound(); q.b_high = pick_bound();
    if ($urandom_range(9) != 0) begin
      if (q.a_low > q.a_high) begin t = q.a_low; q.a_low = q.a_high; q.a_high = t; end
      if (q.b_low > q.b_high) begin t = q.b_low; q.b_low = q.b_high; q.b_high = t; end
    end
    // single-valued intervals feed the not-equal and constant-divisor paths
    if ($urandom_range(4) == 0) q.a_high = q.a_low;
    if ($urandom_range(3) == 0) q.b_high = q.b_low;
    q.cond   = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(9));
    q.a_type = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(8));
    q.b_type = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(8));
    return q;
  endfunction

  task automatic send_request(req_t q);
    int gap;
    in_if.valid  <= 1'b1;
    in_if.action <= q.action;
    in_if.a_low  <= q.a_low;  in_if.a_high <= q.a_high;
    in_if.b_low  <= q.b_low;  in_if.b_high <= q.b_high;
    in_if.cond   <= q.cond;
    in_if.a_type <= q.a_type;
    in_if.b_type <= q.b_type;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    gap = 0;
    while (gap < 200 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    req_t q;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req     = 1'b0;
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.action <= '0;
    in_if.a_low  <= '0; in_if.a_high <= '0;
    in_if.b_low  <= '0; in_if.b_high <= '0;
    in_if.cond   <= '0; in_if.a_type <= '0; in_if.b_type <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: limits, every action, saturation and division corners
    send_request(mk(ACT_NEG, I64_MIN, I64_MAX, 0, 0, CC_EQ, TY_I64, TY_I64));
    send_request(mk(ACT_ABS, -64'sd5, 64'sd3, 0, 0, CC_EQ, TY_U8, TY_I64));
    send_request(mk(ACT_ABS, I64_MIN, -64'sd7, 0, 0, CC_EQ, TY_I64, TY_I64));
    send_request(mk(ACT_ADD, I64_MAX - 1, I64_MAX, 64'sd5, 64'sd9, CC_EQ, TY_I64, TY_I64));
    send_request(mk(ACT_SUB, I64_MIN, 0, 64'sd1, I64_MAX, CC_EQ, TY_I32, TY_I64));
    send_request(mk(ACT_MUL, I64_MIN, 64'sd3, -64'sd1, 64'sd2, CC_EQ, TY_I64, TY_I64));
    send_request(mk(ACT_MUL, -64'sd4, 64'sd6, -64'sd3, 64'sd5, CC_EQ, TY_I8, TY_I64));
    send_request(mk(ACT_DIV, I64_MIN, 64'sd10, -64'sd1, -64'sd1, CC_EQ, TY_I64, TY_I64));
    send_request(mk(ACT_DIV, -64'sd7, 64'sd9, 64'sd2, 64'sd2, CC_EQ, TY_I16, TY_I64));
    send_request(mk(ACT_DIV, 64'sd1, 64'sd9, 0, 0, CC_EQ, TY_I64, TY_I64));
    send_request(mk(ACT_MOD, 64'sd1, 64'sd9, -64'sd3, 0, CC_EQ, TY_U32, TY_I64));
    send_request(mk(ACT_MOD, 64'sd1, 64'sd9, I64_MIN, I64_MIN, CC_EQ, TY_REF, TY_I64));
    send_request(mk(ACT_JOIN, 64'sd2, 64'sd4, -64'sd1, 64'sd1, CC_EQ, TY_BOOL, TY_U16));
    send_request(mk(4'hF, 64'sd1, 64'sd2, 64'sd3, 64'sd4, CC_EQ, 4'hF, 4'hF));
    // not-equal: single value sitting on the other interval's ends
    send_request(mk(ACT_NARROW, 64'sd3, 64'sd3, 64'sd3, 64'sd8, CC_NE, TY_I64, TY_I64));
    send_request(mk(ACT_NARROW, 64'sd2, 64'sd9, 64'sd9, 64'sd9, CC_NE, TY_I64, TY_I64));
    send_request(mk(ACT_NARROW, I64_MIN, 64'sd0, I64_MIN, I64_MIN, CC_NE, TY_I64, TY_I64));
    // every condition code on a partial overlap, plus codes past the end
    for (int c = 0; c < 16; c++)
      send_request(mk(ACT_NARROW, 64'sd0, 64'sd10, 64'sd5, 64'sd20, 4'(c), TY_U8, TY_I8));
    // impossible comparison: disjoint intervals
    send_request(mk(ACT_NARROW, 64'sd0, 64'sd3, 64'sd7, 64'sd9, CC_GT, TY_I64, TY_REF));
    // inverted interval passes through as given
    send_request(mk(ACT_NARROW, 64'sd9, 64'sd1, 64'sd4, 64'sd2, CC_LE, TY_I64, TY_I64));
    drain();

    // Random phases with different idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 88; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 88; end
        default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
      endcase
      for (int i = 0; i < 150; i++) begin
        q = random_request();
        send_request(q);
      end
      // pause the sender until every result is back
      drain();
    end

    // Back-pressure: receiver holds off long enough for the pipe to fill
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 100; i++) begin
      q = random_request();
      send_request(q);
    end
    drain();

    repeat (60) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
